// File: sv/pct_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the prefix count table
package pct_pkg;

    // fixed widths of the request and result fields
    localparam int LETTER_IN_W = 5;
    localparam int PC_W        = 16;

    // operation codes carried by a request
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    // walk sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_LOOK  = 6'b000100,
        ST_UPD   = 6'b001000,
        ST_READ  = 6'b010000,
        ST_HOLD  = 6'b100000
    } pct_state_t;

endpackage

// File: sv/pct_ram.sv
`timescale 1ns / 1ps
// simple dual port synchronous ram, one write and one registered read port
module pct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/prefix_count_table.sv
`timescale 1ns / 1ps
// prefix count table: trie walk over a child table ram and a node count ram
//
//   channel | direction | ports                                   | moves
//   s_      | in        | s_operation, s_letter, s_last_letter    | one letter request
//   m_      | out       | m_prefix_count, m_overflow              | one find result
//
// A letter passes through accept and child lookup; an add through an existing node
// and the last letter of a find that hits take a further step, the read-modify-write
// or read of the node count ram.
// After reset all MAX_NODES*ALPHABET child table entries (32768 at the defaults)
// are swept to zero, with s_ready low.
// A finished result waits in the output register; a second one waits in a hold
// state, and only then is s_ready held low by a stalled m_ready.
module prefix_count_table #(
    parameter int MAX_NODES  = 1024,
    parameter int ALPHABET   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [pct_pkg::LETTER_IN_W-1:0] s_letter,
    input  logic                            s_last_letter,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pct_pkg::PC_W-1:0]        m_prefix_count,
    output logic                            m_overflow
);
    import pct_pkg::*;

    localparam int NODE_W       = $clog2(MAX_NODES);
    localparam int LETTER_W     = $clog2(ALPHABET);
    localparam int CHILD_DEPTH  = MAX_NODES * ALPHABET;
    localparam int ADDR_W       = $clog2(CHILD_DEPTH);
    localparam int LETTER_COUNT = 2 ** LETTER_IN_W;

    // letter reduction table, letter modulo alphabet size
    logic [LETTER_W-1:0] letter_lut [LETTER_COUNT];
    for (genvar g = 0; g < LETTER_COUNT; g++) begin : g_lut
        assign letter_lut[g] = LETTER_W'(g % ALPHABET);
    end

    pct_state_t state_reg, state_next;

    logic                  op_reg, last_reg;
    logic [ADDR_W-1:0]     slot_reg;
    logic [NODE_W-1:0]     cur_reg, cur_next;
    logic                  missing_reg, missing_next;
    logic                  ovf_reg, ovf_next;
    logic [NODE_W:0]       free_reg, free_next;
    logic [NODE_W-1:0]     child_reg, child_next;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [PC_W-1:0]       hold_reg, hold_next;
    logic                  m_valid_reg, m_valid_next;
    logic [PC_W-1:0]       m_count_reg, m_count_next;
    logic                  m_ovf_reg, m_ovf_next;

    // memory ports
    logic                  child_we;
    logic [ADDR_W-1:0]     child_waddr;
    logic [NODE_W-1:0]     child_wdata;
    logic [ADDR_W-1:0]     child_raddr;
    logic [NODE_W-1:0]     child_rdata;
    logic                  cnt_we;
    logic [NODE_W-1:0]     cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [NODE_W-1:0]     cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_rdata;

    logic                  out_free;
    logic                  emit;
    logic [PC_W-1:0]       emit_val;
    logic [COUNT_BITS+PC_W-1:0] cnt_wide;

    pct_ram #(
        .WIDTH (NODE_W),
        .DEPTH (CHILD_DEPTH)
    ) u_child_ram (
        .aclk    (aclk),
        .wr_en   (child_we),
        .wr_addr (child_waddr),
        .wr_data (child_wdata),
        .rd_addr (child_raddr),
        .rd_data (child_rdata)
    );

    pct_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_NODES)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_addr (cnt_raddr),
        .rd_data (cnt_rdata)
    );

    // child slot of the current node for the letter on the input
    assign child_raddr = ADDR_W'(cur_reg) * ADDR_W'(ALPHABET)
                       + ADDR_W'(letter_lut[s_letter]);

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign cnt_wide = (COUNT_BITS + PC_W)'(cnt_rdata);

    assign m_valid        = m_valid_reg;
    assign m_prefix_count = m_count_reg;
    assign m_overflow     = m_ovf_reg;

    // walk sequencer
    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        missing_next = missing_reg;
        ovf_next     = ovf_reg;
        free_next    = free_reg;
        child_next   = child_reg;
        hold_next    = hold_reg;
        child_we     = 1'b0;
        child_waddr  = slot_reg;
        child_wdata  = free_reg[NODE_W-1:0];
        cnt_we       = 1'b0;
        cnt_waddr    = free_reg[NODE_W-1:0];
        cnt_wdata    = COUNT_BITS'(1);
        cnt_raddr    = child_rdata;
        emit         = 1'b0;
        emit_val     = '0;

        case (state_reg)
            ST_CLEAR: begin
                child_we    = 1'b1;
                child_waddr = clr_addr_reg;
                child_wdata = '0;
                if (clr_addr_reg == ADDR_W'(CHILD_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_IDLE;
                if (!missing_reg) begin
                    if (op_reg == OP_ADD) begin
                        if (child_rdata == '0) begin
                            if (free_reg < (NODE_W + 1)'(MAX_NODES)) begin
                                // allocate a fresh node with count one
                                child_we  = 1'b1;
                                cnt_we    = 1'b1;
                                cur_next  = free_reg[NODE_W-1:0];
                                free_next = free_reg + 1'b1;
                            end else begin
                                ovf_next     = 1'b1;
                                missing_next = 1'b1;
                            end
                        end else begin
                            // existing node, count update next cycle
                            cur_next   = child_rdata;
                            child_next = child_rdata;
                            state_next = ST_UPD;
                        end
                    end else begin
                        if (child_rdata == '0) begin
                            missing_next = 1'b1;
                        end else begin
                            cur_next = child_rdata;
                        end
                    end
                end
                if (last_reg) begin
                    if (op_reg == OP_FIND) begin
                        if (missing_next) begin
                            emit = 1'b1;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                    cur_next     = '0;
                    missing_next = 1'b0;
                end
                if (emit && !out_free) begin
                    hold_next  = '0;
                    state_next = ST_HOLD;
                end
            end
            ST_UPD: begin
                // saturating increment of the node count
                cnt_we     = 1'b1;
                cnt_waddr  = child_reg;
                cnt_wdata  = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ: begin
                emit     = 1'b1;
                emit_val = cnt_wide[PC_W-1:0];
                if (out_free) begin
                    state_next = ST_IDLE;
                end else begin
                    hold_next  = cnt_wide[PC_W-1:0];
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                emit     = 1'b1;
                emit_val = hold_reg;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_count_next = m_count_reg;
        m_ovf_next   = m_ovf_reg;
        if (emit && out_free) begin
            m_valid_next = 1'b1;
            m_count_next = emit_val;
            m_ovf_next   = ovf_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cur_reg      <= '0;
            missing_reg  <= 1'b0;
            ovf_reg      <= 1'b0;
            free_reg     <= (NODE_W + 1)'(1);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_reg + 1'b1;
            cur_reg      <= cur_next;
            missing_reg  <= missing_next;
            ovf_reg      <= ovf_next;
            free_reg     <= free_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // request and payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            last_reg <= s_last_letter;
            slot_reg <= child_raddr;
        end
        child_reg   <= child_next;
        hold_reg    <= hold_next;
        m_count_reg <= m_count_next;
        m_ovf_reg   <= m_ovf_next;
    end

endmodule

// File: sv/pct_checker.sv
`timescale 1ns / 1ps
// port-level checks for the prefix count table, bound to the top level
module pct_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_operation,
    input logic [pct_pkg::LETTER_IN_W-1:0] s_letter,
    input logic                            s_last_letter,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [pct_pkg::PC_W-1:0]        m_prefix_count,
    input logic                            m_overflow
);
    import pct_pkg::*;

    logic [1:0] pend_reg, pend_next;
    logic       seen_reg;
    logic       find_end;
    logic       res_take;

    assign find_end = s_valid && s_ready && (s_operation == OP_FIND) && s_last_letter;
    assign res_take = m_valid && m_ready;

    // results owed for accepted find requests
    always_comb begin
        pend_next = pend_reg;
        if (find_end && !res_take) begin
            pend_next = pend_reg + 1'b1;
        end else if (!find_end && res_take) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            seen_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (res_take && m_overflow) begin
                seen_reg <= 1'b1;
            end
        end
    end

    // reset leaves no result and a busy input while the table clears
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("result or ready shown after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prefix_count) && $stable(m_overflow))
        else $error("stalled result changed");

    // no result without a finished find request
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result with no find request owed");

    // overflow is sticky across results
    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && seen_reg |-> m_overflow)
        else $error("overflow flag dropped");

endmodule

bind prefix_count_table pct_checker u_pct_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the prefix count table
module tb;
    import pct_pkg::*;

    localparam int NODE_LIMIT = 1024;
    localparam int ALPHA      = 32;
    localparam logic [PC_W-1:0] CNT_MAX = 16'hffff;

    // one directed request, with its result typed in where there is one
    typedef struct {
        logic       op;
        logic [4:0] ltr;
        logic       last;
        bit         typed;
        logic [15:0] cnt;
        logic       ovf;
    } letter_req_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_operation;
    logic [LETTER_IN_W-1:0] s_letter;
    logic                   s_last_letter;
    logic                   m_valid;
    logic                   m_ready;
    logic [PC_W-1:0]        m_prefix_count;
    logic                   m_overflow;

    prefix_count_table dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_letter       (s_letter),
        .s_last_letter  (s_last_letter),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_prefix_count (m_prefix_count),
        .m_overflow     (m_overflow)
    );

    // trie held by the testbench
    logic [9:0]      child_tab [NODE_LIMIT*ALPHA];
    logic [PC_W-1:0] node_cnt [NODE_LIMIT];
    int unsigned     free_node;
    int unsigned     walk_node;
    bit              walk_lost;
    bit              ovf_sticky;

    // counts and flags still owed by the block, oldest first
    logic [PC_W-1:0] count_q [$];
    logic            ovf_q [$];

    int mismatches;
    int letters_sent;
    int burst_left;
    int gap_max;

    localparam logic [4:0] COMMON_LETTERS [4] = '{5'd0, 5'd9, 5'd22, 5'd31};

    // directed opening: empty trie, extremes, missing paths, mixed operations
    letter_req_t opening_seq [23] = '{
        '{OP_FIND, 5'd0,  1'b1, 1'b1, 16'd0, 1'b0},
        '{OP_ADD,  5'd0,  1'b1, 1'b0, 16'd0, 1'b0},
        '{OP_FIND, 5'd0,  1'b1, 1'b1, 16'd1, 1'b0},
        '{OP_ADD,  5'd0,  1'b0, 1'b0, 16'd0, 1'b0},
        '{OP_ADD,  5'd31, 1'b1, 1'b0, 16'd0, 1'b0},
        '{OP_FIND, 5'd0,  1'b1, 1'b1, 16'd2, 1'b0},
        '{OP_FIND, 5'd0,  1'b0, 1'b0, 16'd0, 1'b0},
        '{OP_FIND, 5'd31, 1'b1, 1'b1, 16'd1, 1'b0},
        '{OP_FIND, 5'd31, 1'b1, 1'b1, 16'd0, 1'b0},
        '{OP_FIND, 5'd5,  1'b0, 1'b0, 16'd0, 1'b0},
        '{OP_FIND, 5'd0,  1'b1, 1'b1, 16'd0, 1'b0},
        '{OP_ADD,  5'd0,  1'b0, 1'b0, 16'd0, 1'b0},
        '{OP_FIND, 5'd31, 1'b1, 1'b1, 16'd1, 1'b0},
        '{OP_FIND, 5'd0,  1'b1, 1'b1, 16'd3, 1'b0},
        '{OP_FIND, 5'd3,  1'b0, 1'b0, 16'd0, 1'b0},
        '{OP_ADD,  5'd3,  1'b1, 1'b0, 16'd0, 1'b0},
        '{OP_FIND, 5'd3,  1'b1, 1'b1, 16'd0, 1'b0},
        '{OP_FIND, 5'd0,  1'b0, 1'b0, 16'd0, 1'b0},
        '{OP_ADD,  5'd1,  1'b1, 1'b0, 16'd0, 1'b0},
        '{OP_FIND, 5'd0,  1'b0, 1'b0, 16'd0, 1'b0},
        '{OP_FIND, 5'd1,  1'b1, 1'b1, 16'd1, 1'b0},
        '{OP_ADD,  5'd31, 1'b1, 1'b0, 16'd0, 1'b0},
        '{OP_FIND, 5'd31, 1'b1, 1'b1, 16'd1, 1'b0}
    };

    // advance the trie walk by one letter; returns 1 when a find result is due
    function automatic bit trie_step(input logic op, input logic [4:0] ltr, input logic last,
                                     output logic [PC_W-1:0] cnt, output logic ovf);
        int unsigned slot;
        int unsigned child;
        bit due;
        due = 1'b0;
        cnt = '0;
        ovf = 1'b0;
        if (!walk_lost) begin
            slot  = walk_node * ALPHA + (ltr % ALPHA);
            child = 32'(child_tab[slot]);
            if (op == OP_ADD) begin
                if (child == 0) begin
                    if (free_node < NODE_LIMIT) begin
                        child = free_node;
                        free_node++;
                        child_tab[slot] = child[9:0];
                        node_cnt[child] = '0;
                    end else begin
                        ovf_sticky = 1'b1;
                        walk_lost  = 1'b1;
                    end
                end
                if (child != 0) begin
                    if (node_cnt[child] != CNT_MAX)
                        node_cnt[child] = node_cnt[child] + 1'b1;
                    walk_node = child;
                end
            end else if (child == 0) begin
                walk_lost = 1'b1;
            end else begin
                walk_node = child;
            end
        end
        if (last) begin
            if (op == OP_FIND) begin
                due = 1'b1;
                cnt = walk_lost ? '0 : node_cnt[walk_node];
                ovf = ovf_sticky;
            end
            walk_node = 0;
            walk_lost = 1'b0;
        end
        return due;
    endfunction

    task automatic note_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // present one letter request, in bursts with random gaps, and log its result
    task automatic send_letter(input logic op, input logic [4:0] ltr, input logic last,
                               input bit typed, input logic [PC_W-1:0] tcnt, input logic tovf);
        int gap;
        logic [PC_W-1:0] cnt;
        logic ovf;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_letter      <= ltr;
        s_last_letter <= last;
        do @(posedge aclk); while (!s_ready);
        letters_sent++;
        if (trie_step(op, ltr, last, cnt, ovf)) begin
            count_q = {count_q, (typed ? tcnt : cnt)};
            ovf_q   = {ovf_q, (typed ? tovf : ovf)};
        end
    endtask

    // random name or query; mostly a few common letters so that finds hit
    task automatic send_random_name(input int max_len);
        int len;
        logic op;
        bit mixed;
        logic [4:0] ltr;
        len   = $urandom_range(1, max_len);
        op    = 1'($urandom_range(0, 1));
        mixed = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
            if (mixed)
                op = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 4) == 0)
                ltr = 5'($urandom);
            else
                ltr = COMMON_LETTERS[$urandom_range(0, 3)];
            send_letter(op, ltr, i == len - 1, 1'b0, '0, 1'b0);
        end
    endtask

    // hold the sender off until every owed result has arrived
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid    <= 1'b0;
        burst_left = 0;
        while (count_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver stalls in modes of random length
    initial begin
        int mode;
        int span;
        m_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(32, 400);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ($urandom_range(0, 29) == 0);
                endcase
            end
        end
    end

    // compare each result with the oldest owed one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (count_q.size() == 0) begin
                note_mismatch($sformatf("unexpected result count %0d", m_prefix_count));
            end else begin
                if (m_prefix_count !== count_q[0])
                    note_mismatch($sformatf("prefix_count %0d, wanted %0d",
                                            m_prefix_count, count_q[0]));
                if (m_overflow !== ovf_q[0])
                    note_mismatch($sformatf("overflow %0b, wanted %0b",
                                            m_overflow, ovf_q[0]));
                void'(count_q.pop_front());
                void'(ovf_q.pop_front());
            end
        end
    end

    // run limit, well past the clearing sweep and the slowest receiver
    initial begin
        #(64'd40_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus
    initial begin
        int start;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_operation   = OP_ADD;
        s_letter      = '0;
        s_last_letter = 1'b0;
        mismatches    = 0;
        letters_sent  = 0;
        burst_left    = 0;
        gap_max       = 4;
        for (int i = 0; i < NODE_LIMIT * ALPHA; i++)
            child_tab[i] = '0;
        for (int i = 0; i < NODE_LIMIT; i++)
            node_cnt[i] = '0;
        free_node  = 1;
        walk_node  = 0;
        walk_lost  = 1'b0;
        ovf_sticky = 1'b0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed opening
        foreach (opening_seq[i])
            send_letter(opening_seq[i].op, opening_seq[i].ltr, opening_seq[i].last,
                        opening_seq[i].typed, opening_seq[i].cnt, opening_seq[i].ovf);
        wait_for_results();

        // random names and queries
        gap_max = 6;
        start   = letters_sent;
        while (letters_sent < start + 680)
            send_random_name(6);
        wait_for_results();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/pct_pkg.sv
sv/pct_ram.sv
sv/prefix_count_table.sv
sv/pct_checker.sv
dv/tb.sv
